[hdl/intel_hex_record_loader_assert.svh]
// Assertion helpers shared by the loader modules.
// Both forms sample on clock and stay quiet while reset is high.
`ifndef INTEL_HEX_RECORD_LOADER_ASSERT_SVH
`define INTEL_HEX_RECORD_LOADER_ASSERT_SVH
`ifndef SYNTHESIS
`define IHL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("loader assertion failed");
`define IHL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("loader assertion failed");
`else
`define IHL_ASSERT_SAME(label, ante, cons)
`define IHL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/ihex_pkg.sv]
package ihex_pkg;

   localparam int DEF_MEM_DEPTH  = 65536;
   localparam int DEF_MAX_RECORD = 256;

   // Characters of the hex stream
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;

   // Record types
   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF  = 8'h01;

   localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;
   localparam logic [16:0] NO_LOW    = 17'h10000;

   typedef enum logic [2:0] {
      KIND_DATA  = 3'd0,
      KIND_END   = 3'd1,
      KIND_OTHER = 3'd2,
      KIND_ERROR = 3'd3,
      KIND_READ  = 3'd4
   } kind_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   // Staging buffer write from the parser
   typedef struct packed {
      logic       en;
      logic [7:0] idx;
      logic [7:0] data;
   } stage_wr_type;

   // Status of a line at its newline
   typedef struct packed {
      logic        fire;
      logic        ok;
      logic [7:0]  rec_type;
      logic [7:0]  length;
      logic [15:0] address;
   } line_end_type;

   // Commit launch from the controller
   typedef struct packed {
      logic        en;
      logic [15:0] address;
      logic [7:0]  length;
   } commit_start_type;

   // Commit engine status and image read data
   typedef struct packed {
      logic        busy;
      logic [19:0] total;
      logic [16:0] low;
      logic [15:0] high;
      logic [7:0]  rdata;
   } commit_stat_type;

   function automatic hex_digit_type hex_digit(input logic [7:0] c);
      hex_digit_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r.value = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         r.value = 4'(c - CHAR_UP_A + 8'd10);
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
         r.value = 4'(c - CHAR_LO_A + 8'd10);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

[hdl/ihex_if.sv]
interface ihex_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  char_code;
   logic [15:0] read_addr;

   modport source (output valid, output opcode, output char_code, output read_addr,
                   input ready);
   modport sink (input valid, input opcode, input char_code, input read_addr,
                 output ready);
endinterface

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  byte_count;
   logic [19:0] total_bytes;
   logic [16:0] lowest_addr;
   logic [15:0] highest_addr;
   logic [16:0] image_end;
   logic [7:0]  read_byte;

   modport source (output valid, output kind, output byte_count, output total_bytes,
                   output lowest_addr, output highest_addr, output image_end,
                   output read_byte, input ready);
   modport sink (input valid, input kind, input byte_count, input total_bytes,
                 input lowest_addr, input highest_addr, input image_end,
                 input read_byte, output ready);
endinterface

[hdl/intel_hex_record_loader.sv]
// Intel HEX record loader.
// req_ch carries one item per request: opcode 0 feeds one ASCII character of
// the hex stream, opcode 1 reads one byte of the image memory at read_addr.
// rsp_ch returns at most one result per request: a record status at each
// newline before an end record is accepted (data, end, other type or line
// error) or the byte of a read. A character that ends no line gives none.
// A newline that closes an error, end or other-type line passes through
// ST_EMIT into the output register. A good data record is copied from the
// staging buffer into the image memory one byte per cycle before ST_EMIT;
// the image memory has a single write port, and ready stays low until the
// result is loaded. A read passes through the registered read port and
// ST_EMIT into the output register.
// Reset clears the parser, the byte total and the address marks; the image
// memory and staging buffer keep no reset value and are defined once written.
// A result waits in the output register while rsp_ch stalls; characters that
// give no result are still taken meanwhile, and the block holds ready low once
// it has a second result to deliver.
`include "intel_hex_record_loader_assert.svh"

module intel_hex_record_loader #(
   parameter int MEM_DEPTH  = ihex_pkg::DEF_MEM_DEPTH,
   parameter int MAX_RECORD = ihex_pkg::DEF_MAX_RECORD
) (
   input logic        clock,
   input logic        reset,
   ihex_req_if.sink   req_ch,
   ihex_rsp_if.source rsp_ch
);
   import ihex_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_COMMIT = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   kind_type         pend_kind_ff, pend_kind_in;
   logic [7:0]       pend_count_ff, pend_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_kind_ff;
   logic [7:0]       rsp_count_ff;
   logic [19:0]      rsp_total_ff;
   logic [16:0]      rsp_low_ff;
   logic [15:0]      rsp_high_ff;
   logic [16:0]      rsp_end_ff;
   logic [7:0]       rsp_byte_ff;
   logic             accept;
   logic             step;
   logic             rd_en;
   logic             load;
   line_end_type     line_end;
   stage_wr_type     stage_wr;
   commit_start_type start;
   commit_stat_type  cstat;

   assign req_ch.ready = state_ff == ST_IDLE;
   assign accept       = req_ch.valid && req_ch.ready;
   assign step         = accept && !req_ch.opcode;
   assign rd_en        = accept && req_ch.opcode;

   ihex_parser #(
      .MAX_RECORD(MAX_RECORD)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .char_code(req_ch.char_code),
      .line_end (line_end),
      .stage_wr (stage_wr)
   );

   ihex_commit #(
      .MEM_DEPTH (MEM_DEPTH),
      .MAX_RECORD(MAX_RECORD)
   ) u_commit (
      .clock   (clock),
      .reset   (reset),
      .stage_wr(stage_wr),
      .start   (start),
      .rd_en   (rd_en),
      .rd_addr (req_ch.read_addr),
      .stat    (cstat)
   );

   // Sequence each request and decide its result
   always_comb begin
      state_in      = state_ff;
      pend_kind_in  = pend_kind_ff;
      pend_count_in = pend_count_ff;
      start         = '0;
      load          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (rd_en) begin
               pend_kind_in  = KIND_READ;
               pend_count_in = 8'd0;
               state_in      = ST_EMIT;
            end else if (line_end.fire) begin
               pend_count_in = line_end.length;
               state_in      = ST_EMIT;
               if (!line_end.ok) begin
                  pend_kind_in  = KIND_ERROR;
                  pend_count_in = 8'd0;
               end else if (line_end.rec_type == REC_DATA) begin
                  pend_kind_in  = KIND_DATA;
                  start.en      = 1'b1;
                  start.address = line_end.address;
                  start.length  = line_end.length;
                  state_in      = ST_COMMIT;
               end else if (line_end.rec_type == REC_EOF) begin
                  pend_kind_in = KIND_END;
               end else begin
                  pend_kind_in = KIND_OTHER;
               end
            end
         end
         ST_COMMIT: begin
            if (!cstat.busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the pending result and fill the output register
   always_ff @(posedge clock) begin
      pend_kind_ff  <= pend_kind_in;
      pend_count_ff <= pend_count_in;
      if (load) begin
         rsp_kind_ff  <= pend_kind_ff;
         rsp_count_ff <= pend_count_ff;
         rsp_total_ff <= cstat.total;
         rsp_low_ff   <= cstat.low;
         rsp_high_ff  <= cstat.high;
         rsp_end_ff   <= (pend_kind_ff == KIND_END) ? 17'(cstat.high) + 17'd1 : 17'd0;
         rsp_byte_ff  <= (pend_kind_ff == KIND_READ) ? cstat.rdata : 8'd0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_kind_ff;
   assign rsp_ch.byte_count   = rsp_count_ff;
   assign rsp_ch.total_bytes  = rsp_total_ff;
   assign rsp_ch.lowest_addr  = rsp_low_ff;
   assign rsp_ch.highest_addr = rsp_high_ff;
   assign rsp_ch.image_end    = rsp_end_ff;
   assign rsp_ch.read_byte    = rsp_byte_ff;

   `IHL_ASSERT_SAME(a_fire_idle, line_end.fire, !cstat.busy && state_ff == ST_IDLE)
   `IHL_ASSERT_NEXT(a_read_emit, rd_en, state_ff == ST_EMIT && pend_kind_ff == KIND_READ)
   `IHL_ASSERT_NEXT(a_emit_load, load, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

[hdl/ihex_parser.sv]
module ihex_parser #(
   parameter int MAX_RECORD = ihex_pkg::DEF_MAX_RECORD
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            char_code,
   output ihex_pkg::line_end_type line_end,
   output ihex_pkg::stage_wr_type stage_wr
);
   import ihex_pkg::*;

   typedef enum logic [6:0] {
      PH_COLON = 7'b0000001,
      PH_LEN   = 7'b0000010,
      PH_ADDR  = 7'b0000100,
      PH_TYPE  = 7'b0001000,
      PH_DATA  = 7'b0010000,
      PH_CKSUM = 7'b0100000,
      PH_DONE  = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hi_ff, hi_in;
   logic        pend_ff, pend_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  sum_ff, sum_in;
   logic        bad_ff, bad_in;
   logic        finished_ff, finished_in;

   hex_digit_type digit;
   logic [7:0]    rec_byte;

   assign digit    = hex_digit(char_code);
   assign rec_byte = {hi_ff, digit.value};

   // Parse one character per step
   always_comb begin
      phase_in    = phase_ff;
      hi_in       = hi_ff;
      pend_in     = pend_ff;
      len_in      = len_ff;
      addr_in     = addr_ff;
      type_in     = type_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      bad_in      = bad_ff;
      finished_in = finished_ff;
      line_end    = '0;
      stage_wr    = '0;

      if (step && !finished_ff) begin
         if (char_code == CHAR_LF) begin
            // Close the line and reset the record state
            line_end.fire     = 1'b1;
            line_end.ok       = !bad_ff && phase_ff == PH_DONE && sum_ff == 8'd0;
            line_end.rec_type = type_ff;
            line_end.length   = len_ff;
            line_end.address  = addr_ff;
            if (line_end.ok && type_ff == REC_EOF) begin
               finished_in = 1'b1;
            end
            phase_in = PH_COLON;
            hi_in    = 4'd0;
            pend_in  = 1'b0;
            len_in   = 8'd0;
            addr_in  = 16'd0;
            type_in  = 8'd0;
            idx_in   = 8'd0;
            sum_in   = 8'd0;
            bad_in   = 1'b0;
         end else if (char_code != CHAR_CR && phase_ff != PH_DONE) begin
            if (phase_ff == PH_COLON) begin
               if (char_code == CHAR_COLON) begin
                  phase_in = PH_LEN;
               end else begin
                  bad_in   = 1'b1;
                  phase_in = PH_DONE;
               end
            end else if (!digit.ok) begin
               bad_in   = 1'b1;
               phase_in = PH_DONE;
            end else if (!pend_ff) begin
               hi_in   = digit.value;
               pend_in = 1'b1;
            end else begin
               // Complete byte: fold into checksum and route by field
               pend_in = 1'b0;
               sum_in  = sum_ff + rec_byte;
               unique case (phase_ff)
                  PH_LEN: begin
                     len_in = rec_byte;
                     if ({1'b0, rec_byte} >= 9'(MAX_RECORD)) begin
                        bad_in = 1'b1;
                     end
                     idx_in   = 8'd0;
                     phase_in = PH_ADDR;
                  end
                  PH_ADDR: begin
                     addr_in = {addr_ff[7:0], rec_byte};
                     idx_in  = idx_ff + 8'd1;
                     if (idx_ff + 8'd1 >= 8'd2) begin
                        phase_in = PH_TYPE;
                     end
                  end
                  PH_TYPE: begin
                     type_in  = rec_byte;
                     idx_in   = 8'd0;
                     phase_in = (len_ff == 8'd0) ? PH_CKSUM : PH_DATA;
                  end
                  PH_DATA: begin
                     stage_wr.en   = !bad_ff;
                     stage_wr.idx  = idx_ff;
                     stage_wr.data = rec_byte;
                     idx_in        = idx_ff + 8'd1;
                     if (idx_ff + 8'd1 == len_ff) begin
                        phase_in = PH_CKSUM;
                     end
                  end
                  default: begin
                     phase_in = PH_DONE;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COLON;
         hi_ff       <= 4'd0;
         pend_ff     <= 1'b0;
         len_ff      <= 8'd0;
         addr_ff     <= 16'd0;
         type_ff     <= 8'd0;
         idx_ff      <= 8'd0;
         sum_ff      <= 8'd0;
         bad_ff      <= 1'b0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         hi_ff       <= hi_in;
         pend_ff     <= pend_in;
         len_ff      <= len_in;
         addr_ff     <= addr_in;
         type_ff     <= type_in;
         idx_ff      <= idx_in;
         sum_ff      <= sum_in;
         bad_ff      <= bad_in;
         finished_ff <= finished_in;
      end
   end

endmodule

[hdl/ihex_commit.sv]
`include "intel_hex_record_loader_assert.svh"

module ihex_commit #(
   parameter int MEM_DEPTH  = ihex_pkg::DEF_MEM_DEPTH,
   parameter int MAX_RECORD = ihex_pkg::DEF_MAX_RECORD
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ihex_pkg::stage_wr_type    stage_wr,
   input  ihex_pkg::commit_start_type start,
   input  logic                      rd_en,
   input  logic [15:0]               rd_addr,
   output ihex_pkg::commit_stat_type stat
);
   import ihex_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int SW = $clog2(MAX_RECORD);

   logic [7:0] stage_mem [MAX_RECORD];
   logic [7:0] image_mem [MEM_DEPTH];

   logic          issue_ff, issue_in;
   logic          wvalid_ff, wvalid_in;
   logic [7:0]    idx_ff, idx_in;
   logic [7:0]    len_ff, len_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   logic [7:0]    stage_q_ff;
   logic [7:0]    rdata_ff;
   logic [19:0]   total_ff, total_in;
   logic [16:0]   low_ff, low_in;
   logic [15:0]   high_ff, high_in;

   // Sequence staging reads in the cycle before their image writes and track the byte total and address marks
   always_comb begin
      issue_in  = issue_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      waddr_in  = waddr_ff;
      wvalid_in = issue_ff;
      total_in  = total_ff;
      low_in    = low_ff;
      high_in   = high_ff;

      if (start.en) begin
         issue_in = start.length != 8'd0;
         idx_in   = 8'd0;
         len_in   = start.length;
         waddr_in = start.address[AW-1:0];
      end else if (issue_ff) begin
         idx_in = idx_ff + 8'd1;
         if (idx_ff + 8'd1 == len_ff) begin
            issue_in = 1'b0;
         end
      end

      if (wvalid_ff) begin
         waddr_in = waddr_ff + AW'(1);
         if (total_ff != TOTAL_MAX) begin
            total_in = total_ff + 20'd1;
         end
         if (17'(waddr_ff) < low_ff) begin
            low_in = 17'(waddr_ff);
         end
         if (16'(waddr_ff) > high_ff) begin
            high_in = 16'(waddr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         wvalid_ff <= 1'b0;
         total_ff  <= 20'd0;
         low_ff    <= NO_LOW;
         high_ff   <= 16'd0;
      end else begin
         issue_ff  <= issue_in;
         wvalid_ff <= wvalid_in;
         total_ff  <= total_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      len_ff   <= len_in;
      waddr_ff <= waddr_in;
   end

   // Staging buffer: parser writes, commit reads
   always_ff @(posedge clock) begin
      if (stage_wr.en) begin
         stage_mem[stage_wr.idx[SW-1:0]] <= stage_wr.data;
      end
      if (issue_ff) begin
         stage_q_ff <= stage_mem[idx_ff[SW-1:0]];
      end
   end

   // Image memory: commit writes, requests read
   always_ff @(posedge clock) begin
      if (wvalid_ff) begin
         image_mem[waddr_ff] <= stage_q_ff;
      end
      if (rd_en) begin
         rdata_ff <= image_mem[rd_addr[AW-1:0]];
      end
   end

   assign stat.busy  = issue_ff || wvalid_ff;
   assign stat.total = total_ff;
   assign stat.low   = low_ff;
   assign stat.high  = high_ff;
   assign stat.rdata = rdata_ff;

   `IHL_ASSERT_SAME(a_start_idle, start.en, !issue_ff && !wvalid_ff && !stage_wr.en)
   `IHL_ASSERT_NEXT(a_issue_writes, issue_ff, wvalid_ff)
   `IHL_ASSERT_SAME(a_marks_order, low_ff != NO_LOW, 17'(high_ff) >= low_ff)

endmodule
